@@ src/vector_lane_compare_macros.svh @@
// assertion macros for the vector lane compare block
// used by vector_lane_compare.sv
`ifndef VECTOR_LANE_COMPARE_MACROS_SVH
`define VECTOR_LANE_COMPARE_MACROS_SVH

// property that must hold at every edge outside reset
`define VLC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("vector_lane_compare check failed");

// implication checked with the non-overlapping |=> operator
`define VLC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("vector_lane_compare sequence check failed");

`endif

@@ src/vlc_pkg.sv @@
// types and codes for the vector lane compare block
// no dependencies
`default_nettype none
package vlc_pkg;
    typedef enum logic [4:0] {
        KIND_F_LT   = 5'd0,
        KIND_F_EQ   = 5'd1,
        KIND_F_GT   = 5'd2,
        KIND_F_GE   = 5'd3,
        KIND_F_ORD  = 5'd4,
        KIND_F_NGT  = 5'd5,
        KIND_F_NEQ  = 5'd6,
        KIND_I_LT   = 5'd7,
        KIND_I_EQ   = 5'd8,
        KIND_I_LE   = 5'd9,
        KIND_I_GT   = 5'd10,
        KIND_I_NE   = 5'd11,
        KIND_I_GE   = 5'd12,
        KIND_U_LT   = 5'd13,
        KIND_U_EQ   = 5'd14,
        KIND_U_LE   = 5'd15,
        KIND_U_GT   = 5'd16,
        KIND_U_NE   = 5'd17,
        KIND_U_GE   = 5'd18,
        KIND_U64_NE = 5'd19
    } kind_t;

    localparam int LANE_W = 6;

    typedef struct packed {
        logic [4:0]        kind;
        logic [LANE_W-1:0] lane_index;
        logic              use_literal;
        logic [31:0]       literal_value;
        logic [63:0]       operand_a;
        logic [63:0]       operand_b;
    } cmp_req_t;

    typedef struct packed {
        logic [LANE_W-1:0] lane_out;
        logic              condition;
    } cmp_rsp_t;
endpackage
`default_nettype wire

@@ src/vlc_stream_if.sv @@
// valid/ready channel carrying one payload beat
// payload type is a parameter, normally from vlc_pkg
`default_nettype none
interface vlc_stream_if #(parameter type payload_t = logic [0:0]);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ src/vector_lane_compare.sv @@
// vector_lane_compare: per-lane compare, one condition bit per beat
// uses vlc_pkg, vlc_stream_if and vector_lane_compare_macros.svh
//
// channels: in_ch carries one compare request per beat (kind, lane, literal
// select, literal, two 64-bit operands); out_ch returns the lane number and
// its condition bit. requests are registered on acceptance, the compare is
// done by the logic between the request register and the result register.
// an accepted beat passes through the request register and then the result
// register, which drives out_ch valid and payload.
// throughput: one beat per cycle while out_ch is ready; in the two-stage
// register pipeline each stage advances when the next is empty or draining.
// a stall on out_ch holds the result register and then the request register;
// in_ch.ready drops only when both are full, so no beat is lost.
// reset clears both valid flags; payload registers are not reset.
// float compares follow ieee binary32 ordering: a nan makes ordered kinds
// false and negated kinds true, and the two zeros compare equal.
// the literal replaces operand a; for the 64-bit kind it is sign-extended.
// kinds above the 64-bit compare give a false condition.
`default_nettype none
`include "vector_lane_compare_macros.svh"
module vector_lane_compare
    import vlc_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    vlc_stream_if.sink   in_ch,
    vlc_stream_if.source out_ch
);
    cmp_req_t req_reg;
    logic     req_valid_reg;
    cmp_rsp_t rsp_reg, rsp_next;
    logic     rsp_valid_reg;

    logic rsp_advance;
    logic req_advance;

    // result stage takes a new value when empty or being read
    assign rsp_advance = !rsp_valid_reg || out_ch.ready;
    assign req_advance = !req_valid_reg || rsp_advance;
    assign in_ch.ready = req_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_advance)
                req_valid_reg <= in_ch.valid;
            if (rsp_advance)
                rsp_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_advance && in_ch.valid)
            req_reg <= in_ch.payload;
        if (rsp_advance && req_valid_reg)
            rsp_reg <= rsp_next;
    end

    // operand selection
    logic [63:0] a64;
    logic [31:0] a32, b32;
    assign a64 = req_reg.use_literal
        ? {{32{req_reg.literal_value[31]}}, req_reg.literal_value}
        : req_reg.operand_a;
    assign a32 = a64[31:0];
    assign b32 = req_reg.operand_b[31:0];

    // float ordering key: sign-magnitude to offset binary, zeros coincide
    logic        a_nan, b_nan, unord;
    logic [31:0] ka, kb;
    assign a_nan = a32[30:0] > 31'h7F800000;
    assign b_nan = b32[30:0] > 31'h7F800000;
    assign unord = a_nan || b_nan;
    assign ka = a32[31] ? (32'h80000000 - {1'b0, a32[30:0]})
                        : (32'h80000000 + {1'b0, a32[30:0]});
    assign kb = b32[31] ? (32'h80000000 - {1'b0, b32[30:0]})
                        : (32'h80000000 + {1'b0, b32[30:0]});

    logic f_lt, f_eq, u_lt, u_eq, s_lt;
    assign f_lt = ka < kb;
    assign f_eq = ka == kb;
    assign u_lt = a32 < b32;
    assign u_eq = a32 == b32;
    assign s_lt = $signed(a32) < $signed(b32);

    logic cond;
    always_comb
    begin
        case (req_reg.kind)
            KIND_F_LT:   cond = !unord && f_lt;
            KIND_F_EQ:   cond = !unord && f_eq;
            KIND_F_GT:   cond = !unord && !f_lt && !f_eq;
            KIND_F_GE:   cond = !unord && !f_lt;
            KIND_F_ORD:  cond = !unord;
            KIND_F_NGT:  cond = unord || f_lt || f_eq;
            KIND_F_NEQ:  cond = unord || !f_eq;
            KIND_I_LT:   cond = s_lt;
            KIND_I_EQ:   cond = u_eq;
            KIND_I_LE:   cond = s_lt || u_eq;
            KIND_I_GT:   cond = !s_lt && !u_eq;
            KIND_I_NE:   cond = !u_eq;
            KIND_I_GE:   cond = !s_lt;
            KIND_U_LT:   cond = u_lt;
            KIND_U_EQ:   cond = u_eq;
            KIND_U_LE:   cond = u_lt || u_eq;
            KIND_U_GT:   cond = !u_lt && !u_eq;
            KIND_U_NE:   cond = !u_eq;
            KIND_U_GE:   cond = !u_lt;
            KIND_U64_NE: cond = a64 != req_reg.operand_b;
            default:     cond = 1'b0;
        endcase
    end

    always_comb
    begin
        rsp_next.lane_out  = req_reg.lane_index;
        rsp_next.condition = cond;
    end

    assign out_ch.valid   = rsp_valid_reg;
    assign out_ch.payload = rsp_reg;

    // a held result stays put while the receiver stalls
    `VLC_ASSERT_NEXT(a_rsp_hold, rsp_valid_reg && !out_ch.ready,
        rsp_valid_reg && $stable(rsp_reg))
    // input is refused only when both stages are full
    `VLC_ASSERT(a_ready_full, !in_ch.ready |-> (req_valid_reg && rsp_valid_reg))
    // an accepted beat occupies the request stage next cycle
    `VLC_ASSERT_NEXT(a_req_load, in_ch.valid && in_ch.ready, req_valid_reg)
endmodule
`default_nettype wire

@@ tb/sv/vector_lane_compare_tb.sv @@
// testbench for vector_lane_compare: directed and random compare beats,
// checked against an in-bench predictor of the lane condition bit
// depends on vlc_pkg, vlc_stream_if and the vector_lane_compare rtl
`default_nettype none
module vector_lane_compare_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vlc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BEATS = 410;

    logic clk;
    logic rst_n;

    vlc_stream_if #(.payload_t(cmp_req_t)) in_ch ();
    vlc_stream_if #(.payload_t(cmp_rsp_t)) out_ch ();

    vector_lane_compare dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // expected lane results, oldest first
    cmp_rsp_t pending_conds[$];
    int       fail_count;
    int       cycle_count;
    bit       hold_ready;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ieee binary32 helpers working on raw bits
    function automatic bit is_nan32(logic [31:0] x);
        return x[30:0] > 31'h7F800000;
    endfunction

    // order key: monotone for non-nan values, both zeros share one key
    function automatic logic [31:0] order_key(logic [31:0] x);
        if (x[31])
            return 32'h80000000 - {1'b0, x[30:0]};
        return 32'h80000000 + {1'b0, x[30:0]};
    endfunction

    // relation group shared by signed and unsigned kinds: lt eq le gt ne ge
    function automatic bit rel_hold(int rel, logic [31:0] a, logic [31:0] b);
        case (rel)
            0: return a < b;
            1: return a == b;
            2: return a <= b;
            3: return a > b;
            4: return a != b;
            5: return a >= b;
            default: return 1'b0;
        endcase
    endfunction

    function automatic cmp_rsp_t predict_condition(cmp_req_t rq);
        logic [63:0] a64;
        logic [31:0] a, b, ka, kb;
        bit          unord;
        cmp_rsp_t    rs;
        a64 = rq.use_literal ? {{32{rq.literal_value[31]}}, rq.literal_value}
                             : rq.operand_a;
        a = a64[31:0];
        b = rq.operand_b[31:0];
        unord = is_nan32(a) || is_nan32(b);
        ka = order_key(a);
        kb = order_key(b);
        rs.lane_out = rq.lane_index;
        case (rq.kind)
            KIND_F_LT:   rs.condition = !unord && ka < kb;
            KIND_F_EQ:   rs.condition = !unord && ka == kb;
            KIND_F_GT:   rs.condition = !unord && ka > kb;
            KIND_F_GE:   rs.condition = !unord && ka >= kb;
            KIND_F_ORD:  rs.condition = !unord;
            KIND_F_NGT:  rs.condition = unord || !(ka > kb);
            KIND_F_NEQ:  rs.condition = unord || ka != kb;
            KIND_U64_NE: rs.condition = a64 != rq.operand_b;
            default:
            begin
                // signed kinds flip the sign bit and reuse the unsigned relation
                if (rq.kind >= KIND_I_LT && rq.kind <= KIND_I_GE)
                    rs.condition = rel_hold(int'(rq.kind) - int'(KIND_I_LT),
                                            a ^ 32'h80000000, b ^ 32'h80000000);
                else if (rq.kind >= KIND_U_LT && rq.kind <= KIND_U_GE)
                    rs.condition = rel_hold(int'(rq.kind) - int'(KIND_U_LT), a, b);
                else
                    rs.condition = 1'b0;
            end
        endcase
        return rs;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // send one compare beat and record its expected result on acceptance
    task automatic send_compare(cmp_req_t rq);
        int gap;
        gap = hold_ready ? 0 : pick_gap();
        // drop valid at once so the previous beat is not taken again
        if (gap > 0)
            in_ch.valid <= 1'b0;
        repeat (gap)
            @(posedge clk);
        in_ch.valid <= 1'b1;
        in_ch.payload <= rq;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_conds.push_back(predict_condition(rq));
    endtask

    task automatic finish_stream();
        in_ch.valid <= 1'b0;
    endtask

    // random 32-bit value biased towards float and integer corner patterns
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 11))
            0: return 32'h00000000;
            1: return 32'h80000000;
            2: return 32'h7F800000;
            3: return 32'hFF800000;
            4: return 32'h7FC00000 | $urandom_range(0, 255);
            5: return 32'hFF800001;
            6: return 32'h7FFFFFFF;
            7: return 32'hFFFFFFFF;
            8: return 32'h3F800000;
            default: return $urandom();
        endcase
    endfunction

    function automatic cmp_req_t random_request();
        cmp_req_t rq;
        rq.kind = 5'((($urandom_range(0, 19) == 0) ? $urandom_range(20, 31)
                                                   : $urandom_range(0, 19)));
        rq.lane_index = 6'($urandom_range(0, 63));
        rq.use_literal = $urandom_range(0, 3) == 0;
        rq.literal_value = pick_word();
        rq.operand_a = {32'($urandom()), pick_word()};
        rq.operand_b = {32'($urandom()), pick_word()};
        // equal operands often, so that eq/le/ge relations are exercised
        if ($urandom_range(0, 3) == 0)
            rq.operand_b = rq.use_literal
                ? {{32{rq.literal_value[31]}}, rq.literal_value} : rq.operand_a;
        if ($urandom_range(0, 7) == 0)
            rq.operand_b[63:32] = ~rq.operand_b[63:32];
        return rq;
    endfunction

    function automatic cmp_req_t make_req(logic [4:0] k, logic [31:0] a,
                                          logic [31:0] b);
        cmp_req_t rq;
        rq.kind = k;
        rq.lane_index = 6'($urandom_range(0, 63));
        rq.use_literal = 1'b0;
        rq.literal_value = $urandom();
        rq.operand_a = {32'($urandom()), a};
        rq.operand_b = {32'($urandom()), b};
        return rq;
    endfunction

    // every kind once with distinct operands, plus unused kinds
    task automatic test_every_kind();
        cmp_req_t rq;
        for (int k = 0; k < 32; k++)
        begin
            rq = make_req(5'(k), 32'h3F800000, 32'h40000000);
            send_compare(rq);
        end
    endtask

    // float specials: nan, signed zeros, infinities
    task automatic test_float_specials();
        send_compare(make_req(KIND_F_EQ, 32'h80000000, 32'h00000000));
        send_compare(make_req(KIND_F_LT, 32'h7FC00000, 32'h3F800000));
        send_compare(make_req(KIND_F_NGT, 32'h3F800000, 32'hFFC00001));
        send_compare(make_req(KIND_F_NEQ, 32'h7F800001, 32'h7F800001));
        send_compare(make_req(KIND_F_ORD, 32'hFF800000, 32'h7F800000));
        send_compare(make_req(KIND_F_GE, 32'hBF800000, 32'h80000000));
    endtask

    // integer extremes and the literal, with sign extension on the 64-bit kind
    task automatic test_extremes_and_literal();
        cmp_req_t rq;
        rq = make_req(KIND_I_LT, 32'h80000000, 32'h7FFFFFFF);
        rq.lane_index = 6'd63;
        send_compare(rq);
        rq = make_req(KIND_U_LT, 32'h80000000, 32'h7FFFFFFF);
        rq.lane_index = 6'd0;
        send_compare(rq);
        rq = make_req(KIND_U64_NE, 32'h0, 32'hFFFFFFFF);
        rq.use_literal = 1'b1;
        rq.literal_value = 32'hFFFFFFFF;
        rq.operand_b = 64'hFFFFFFFF_FFFFFFFF;
        send_compare(rq);
        rq.operand_b = 64'h00000000_FFFFFFFF;
        send_compare(rq);
        rq = make_req(KIND_U_EQ, 32'h1234, 32'h89ABCDEF);
        rq.use_literal = 1'b1;
        rq.literal_value = 32'h89ABCDEF;
        send_compare(rq);
    endtask

    task automatic test_random_mix();
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            // occasional bursts without source gaps
            hold_ready = (n % 100) < 20;
            send_compare(random_request());
        end
        hold_ready = 1'b0;
    endtask

    // result checker and random back-pressure on the sink side
    always @(posedge clk)
    begin
        cmp_rsp_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_conds.size() == 0)
            begin
                $display("%0t: unexpected result lane %0d cond %0b", $time,
                         out_ch.payload.lane_out, out_ch.payload.condition);
                fail_count++;
            end
            else
            begin
                want = pending_conds.pop_front();
                if (out_ch.payload.lane_out !== want.lane_out)
                begin
                    $display("%0t: lane_out expected %0d actual %0d", $time,
                             want.lane_out, out_ch.payload.lane_out);
                    fail_count++;
                end
                if (out_ch.payload.condition !== want.condition)
                begin
                    $display("%0t: condition expected %0b actual %0b lane %0d",
                             $time, want.condition, out_ch.payload.condition,
                             want.lane_out);
                    fail_count++;
                end
            end
        end
        out_ch.ready <= (cycle_count % 400) < 80 ? 1'b1
                                                 : ($urandom_range(0, 9) < 7);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        hold_ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_every_kind();
        test_float_specials();
        test_extremes_and_literal();
        test_random_mix();
        finish_stream();
        while (pending_conds.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
